// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define SHDF_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// Next-cycle implication, masked while reset is high.
`define SHDF_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

// Next-cycle implication that is also checked across reset.
`define SHDF_ASSERT_NXT_ANY(name, clk, ante, cons) \
   name: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

// ===== design/shdf_pkg.sv =====
package shdf_pkg;

   // Sync word EB 91 EB 90: the first three bytes sit in the window, oldest highest.
   localparam logic [23:0] SYNC_PREFIX = 24'hEB91EB;
   localparam logic [7:0]  SYNC_LAST   = 8'h90;

   // Header byte positions of the fields.
   localparam int unsigned HDR_LEN_LO = 4;
   localparam int unsigned HDR_LEN_HI = 5;
   localparam int unsigned HDR_ID_LO  = 6;
   localparam int unsigned HDR_ID_HI  = 7;
   localparam int unsigned HDR_FORMAT = 8;

   typedef struct packed {
      logic [7:0]  payload_byte;
      logic [15:0] msg_id;
      logic [7:0]  format_code;
      logic [15:0] payload_length;
      logic        last_of_frame;
      logic        empty_frame;
   } shdf_result_type;

endpackage

// ===== design/shdf_parse.sv =====
module shdf_parse import shdf_pkg::*; #(
   parameter int HEADER_BYTES = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_accept,
   input  logic [7:0]      in_byte,
   output logic            res_valid,
   output shdf_result_type res
);

   localparam int POS_W = $clog2(HEADER_BYTES);
   localparam logic [POS_W-1:0] PosLenLo = POS_W'(HDR_LEN_LO);
   localparam logic [POS_W-1:0] PosLenHi = POS_W'(HDR_LEN_HI);
   localparam logic [POS_W-1:0] PosIdLo  = POS_W'(HDR_ID_LO);
   localparam logic [POS_W-1:0] PosIdHi  = POS_W'(HDR_ID_HI);
   localparam logic [POS_W-1:0] PosFmt   = POS_W'(HDR_FORMAT);
   localparam logic [POS_W-1:0] PosLast  = POS_W'(HEADER_BYTES - 1);

   typedef enum logic [1:0] {
      PH_HUNT    = 2'd0,
      PH_HEADER  = 2'd1,
      PH_PAYLOAD = 2'd2
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [23:0]      window_ff, window_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0]      len_ff, len_in;
   logic [15:0]      id_ff, id_in;
   logic [7:0]       fmt_ff, fmt_in;
   logic [15:0]      left_ff, left_in;

   always_comb begin
      phase_in  = phase_ff;
      window_in = window_ff;
      pos_in    = pos_ff;
      len_in    = len_ff;
      id_in     = id_ff;
      fmt_in    = fmt_ff;
      left_in   = left_ff;
      res_valid = 1'b0;
      res.payload_byte  = in_byte;
      res.last_of_frame = 1'b0;
      res.empty_frame   = 1'b0;

      unique case (phase_ff)
         PH_HEADER: begin
            case (pos_ff)
               PosLenLo: len_in[7:0]  = in_byte;
               PosLenHi: len_in[15:8] = in_byte;
               PosIdLo:  id_in[7:0]   = in_byte;
               PosIdHi:  id_in[15:8]  = in_byte;
               PosFmt:   fmt_in       = in_byte;
               default: ;
            endcase
            if (pos_ff >= PosLast) begin
               pos_in = '0;
               if (len_in == 16'd0) begin
                  // An empty frame still reports its header once.
                  phase_in          = PH_HUNT;
                  res_valid         = 1'b1;
                  res.payload_byte  = 8'd0;
                  res.last_of_frame = 1'b1;
                  res.empty_frame   = 1'b1;
               end else begin
                  left_in  = len_in;
                  phase_in = PH_PAYLOAD;
               end
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
         PH_PAYLOAD: begin
            left_in           = left_ff - 16'd1;
            res_valid         = 1'b1;
            res.last_of_frame = (left_in == 16'd0);
            if (left_in == 16'd0) begin
               phase_in = PH_HUNT;
            end
         end
         default: begin
            // Hunting; the unused phase code hunts as well.
            phase_in = PH_HUNT;
            if (window_ff == SYNC_PREFIX && in_byte == SYNC_LAST) begin
               window_in = '0;
               phase_in  = PH_HEADER;
               pos_in    = PosLenLo;
               len_in    = '0;
               id_in     = '0;
               fmt_in    = '0;
            end else begin
               window_in = {window_ff[15:0], in_byte};
            end
         end
      endcase

      res.msg_id         = id_in;
      res.format_code    = fmt_in;
      res.payload_length = len_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         window_ff <= '0;
         pos_ff    <= '0;
         len_ff    <= '0;
         id_ff     <= '0;
         fmt_ff    <= '0;
         left_ff   <= '0;
      end else if (in_accept) begin
         phase_ff  <= phase_in;
         window_ff <= window_in;
         pos_ff    <= pos_in;
         len_ff    <= len_in;
         id_ff     <= id_in;
         fmt_ff    <= fmt_in;
         left_ff   <= left_in;
      end
   end

endmodule

// ===== design/shdf_out_stage.sv =====
module shdf_out_stage import shdf_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            res_valid,
   input  shdf_result_type res,
   output logic            room,
   output logic            out_valid,
   input  logic            out_ready,
   output shdf_result_type out
);

   logic            main_valid_ff, main_valid_in;
   logic            skid_valid_ff, skid_valid_in;
   shdf_result_type main_ff, main_in;
   shdf_result_type skid_ff, skid_in;
   logic            take;

   assign take      = main_valid_ff & out_ready;
   assign room      = ~skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out       = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         // No new input while the skid slot is full; drain it first.
         if (take) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!main_valid_ff || take) begin
         main_in       = res;
         main_valid_in = res_valid;
      end else if (res_valid) begin
         skid_in       = res;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

// ===== design/sync_header_frame_deframer.sv =====
// Sync-word deframer for a byte stream with a length-prefixed header.
// The req channel carries one received byte per transaction (req_in_byte).
// The block hunts for the sync word EB 91 EB 90 with a sliding match, then
// reads the rest of a HEADER_BYTES long header: little-endian length at
// bytes 4-5, little-endian message id at bytes 6-7, format at byte 8.
// Every payload byte then leaves on the rsp channel as one transaction with
// the header fields; the final one has rsp_last_of_frame set. A frame of
// length zero gives one transaction with rsp_empty_frame and
// rsp_last_of_frame set and rsp_payload_byte zero.
// Throughput is one byte per cycle while req_ready is high. A byte that yields a
// result is registered before it shows up on rsp; the result register is loaded
// from the parser state in a single pass.
// When the receiver stalls, one more result is held in a skid register and
// req_ready then drops until the skid slot drains; bytes are never lost.
// A synchronous reset clears the parser to hunting with an empty sync
// window and drops any pending result.
module sync_header_frame_deframer import shdf_pkg::*; #(
   parameter int HEADER_BYTES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_payload_byte,
   output logic [15:0] rsp_msg_id,
   output logic [7:0]  rsp_format_code,
   output logic [15:0] rsp_payload_length,
   output logic        rsp_last_of_frame,
   output logic        rsp_empty_frame
);

   logic            req_accept;
   logic            res_valid;
   shdf_result_type res;
   shdf_result_type out;

   // A byte is taken whenever the skid slot is free; the parser state
   // advances only on an accepted transaction.
   assign req_accept = req_valid & req_ready;

   shdf_parse #(
      .HEADER_BYTES (HEADER_BYTES)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .in_accept (req_accept),
      .in_byte   (req_in_byte),
      .res_valid (res_valid),
      .res       (res)
   );

   // The output stage only sees a result when the byte was accepted.
   shdf_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid & req_accept),
      .res       (res),
      .room      (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out       (out)
   );

   assign rsp_payload_byte   = out.payload_byte;
   assign rsp_msg_id         = out.msg_id;
   assign rsp_format_code    = out.format_code;
   assign rsp_payload_length = out.payload_length;
   assign rsp_last_of_frame  = out.last_of_frame;
   assign rsp_empty_frame    = out.empty_frame;

endmodule

// ===== design/shdf_checker.sv =====
`include "assert_macros.svh"

module shdf_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_payload_byte,
   input logic [15:0] rsp_msg_id,
   input logic [7:0]  rsp_format_code,
   input logic [15:0] rsp_payload_length,
   input logic        rsp_last_of_frame,
   input logic        rsp_empty_frame
);

   // Reset drops any pending result.
   `SHDF_ASSERT_NXT_ANY(a_reset_clears_rsp, clock, reset, !rsp_valid)

   // A stalled result holds its payload.
   `SHDF_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                    rsp_valid && $stable(rsp_payload_byte) && $stable(rsp_payload_length)
                    && $stable(rsp_msg_id) && $stable(rsp_format_code)
                    && $stable(rsp_last_of_frame) && $stable(rsp_empty_frame))

   // An empty frame is always the last of its frame and carries a zero byte.
   `SHDF_ASSERT_IMP(a_empty_is_last, clock, reset, rsp_valid && rsp_empty_frame,
                    rsp_last_of_frame && rsp_payload_byte == 8'd0)

   // The empty flag agrees with the reported length.
   `SHDF_ASSERT_IMP(a_empty_len, clock, reset, rsp_valid,
                    rsp_empty_frame == (rsp_payload_length == 16'd0))

endmodule

bind sync_header_frame_deframer shdf_checker u_shdf_checker (.*);

// ===== verif/sync_header_frame_deframer_test.sv =====
module sync_header_frame_deframer_test;
   import shdf_pkg::*;

   localparam int HEADER_BYTES = 16;
   // Every byte from the sync word onward counts toward the stimulus size.
   localparam int COUNTED_BYTES = 400;
   // Length of the receiver hold-off that fills the result and skid registers.
   localparam int HOLD_OFF_CYCLES = 150;
   // Cycles to wait after the last expected result, for stray late results.
   localparam int DRAIN_CYCLES = 20;

   typedef enum logic [1:0] {SEEK_SYNC, IN_HEADER, IN_PAYLOAD} parse_state_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_in_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_payload_byte;
   logic [15:0] rsp_msg_id;
   logic [7:0]  rsp_format_code;
   logic [15:0] rsp_payload_length;
   logic        rsp_last_of_frame;
   logic        rsp_empty_frame;

   sync_header_frame_deframer #(
      .HEADER_BYTES(HEADER_BYTES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_in_byte(req_in_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload_byte(rsp_payload_byte),
      .rsp_msg_id(rsp_msg_id),
      .rsp_format_code(rsp_format_code),
      .rsp_payload_length(rsp_payload_length),
      .rsp_last_of_frame(rsp_last_of_frame),
      .rsp_empty_frame(rsp_empty_frame)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Stream bytes waiting to be offered, and the results the stream should produce.
   logic [7:0]      stream_bytes[$];
   shdf_result_type expected_results[$];

   int total_bytes = 0;
   int counted_bytes = 0;
   int bytes_offered = 0;
   int bytes_taken = 0;
   int error_count = 0;
   logic req_took = 1'b0;

   // Shadow copy of the deframer state, advanced once per accepted byte.
   parse_state_type parse_state = SEEK_SYNC;
   logic [23:0]  sync_window = '0;
   int unsigned  hdr_pos = 0;
   logic [15:0]  frame_len = '0;
   logic [15:0]  frame_id = '0;
   logic [7:0]   frame_fmt = '0;
   logic [15:0]  bytes_left = '0;

   // Advances the shadow state by one stream byte and queues the result it causes.
   task automatic deframe_byte(input logic [7:0] b);
      shdf_result_type res;
      case (parse_state)
         IN_HEADER: begin
            case (hdr_pos)
               HDR_LEN_LO: frame_len[7:0] = b;
               HDR_LEN_HI: frame_len[15:8] = b;
               HDR_ID_LO:  frame_id[7:0] = b;
               HDR_ID_HI:  frame_id[15:8] = b;
               HDR_FORMAT: frame_fmt = b;
               default: ;
            endcase
            if (hdr_pos >= HEADER_BYTES - 1) begin
               hdr_pos = 0;
               if (frame_len == 16'd0) begin
                  // An empty frame still reports its header once.
                  parse_state = SEEK_SYNC;
                  res.payload_byte = 8'h00;
                  res.msg_id = frame_id;
                  res.format_code = frame_fmt;
                  res.payload_length = frame_len;
                  res.last_of_frame = 1'b1;
                  res.empty_frame = 1'b1;
                  expected_results.push_back(res);
               end else begin
                  bytes_left = frame_len;
                  parse_state = IN_PAYLOAD;
               end
            end else begin
               hdr_pos = hdr_pos + 1;
            end
         end
         IN_PAYLOAD: begin
            bytes_left = bytes_left - 16'd1;
            res.payload_byte = b;
            res.msg_id = frame_id;
            res.format_code = frame_fmt;
            res.payload_length = frame_len;
            res.last_of_frame = (bytes_left == 16'd0);
            res.empty_frame = 1'b0;
            expected_results.push_back(res);
            if (bytes_left == 16'd0) begin
               parse_state = SEEK_SYNC;
            end
         end
         default: begin
            // Hunting: a full sync word clears the window so that frame bytes
            // never take part in the next search.
            parse_state = SEEK_SYNC;
            if (sync_window == SYNC_PREFIX && b == SYNC_LAST) begin
               sync_window = '0;
               parse_state = IN_HEADER;
               hdr_pos = HDR_LEN_LO;
               frame_len = '0;
               frame_id = '0;
               frame_fmt = '0;
            end else begin
               sync_window = {sync_window[15:0], b};
            end
         end
      endcase
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // Queues one frame: sync word, header positions 4 to HEADER_BYTES-1, then
   // payload_sent payload bytes. Only the final frame sends fewer than its length.
   task automatic queue_frame(input logic [15:0] len, input logic [15:0] id,
                              input logic [7:0] fmt, input int payload_sent,
                              input bit sync_payload);
      logic [7:0] sync_word[4];
      sync_word = '{SYNC_PREFIX[23:16], SYNC_PREFIX[15:8], SYNC_PREFIX[7:0], SYNC_LAST};
      foreach (sync_word[i]) stream_bytes.push_back(sync_word[i]);
      for (int p = HDR_LEN_LO; p < HEADER_BYTES; p++) begin
         case (p)
            HDR_LEN_LO: stream_bytes.push_back(len[7:0]);
            HDR_LEN_HI: stream_bytes.push_back(len[15:8]);
            HDR_ID_LO:  stream_bytes.push_back(id[7:0]);
            HDR_ID_HI:  stream_bytes.push_back(id[15:8]);
            HDR_FORMAT: stream_bytes.push_back(fmt);
            default:    stream_bytes.push_back(8'($urandom));
         endcase
      end
      // A payload may carry the sync word itself; it must not restart the parser.
      for (int i = 0; i < payload_sent; i++) begin
         if (sync_payload) stream_bytes.push_back(sync_word[i % 4]);
         else stream_bytes.push_back(8'($urandom));
      end
      counted_bytes += HEADER_BYTES + payload_sent;
   endtask

   // Bytes in the hunting phase before a frame: nothing, random noise, a
   // sync word broken off early, or a partial match that overlaps the real one.
   task automatic queue_hunt_bytes();
      int n;
      case ($urandom_range(9))
         6: begin
            n = $urandom_range(4, 1);
            repeat (n) stream_bytes.push_back(8'($urandom));
         end
         7: begin
            stream_bytes.push_back(SYNC_PREFIX[23:16]);
            stream_bytes.push_back(SYNC_PREFIX[15:8]);
            stream_bytes.push_back(SYNC_PREFIX[7:0]);
            stream_bytes.push_back(8'($urandom));
         end
         8: begin
            stream_bytes.push_back(SYNC_PREFIX[23:16]);
            stream_bytes.push_back(SYNC_PREFIX[15:8]);
         end
         9: begin
            stream_bytes.push_back(SYNC_PREFIX[23:16]);
         end
         default: ;
      endcase
   endtask

   // Idle percentages per stimulus phase: none, sender, receiver, both, none.
   function automatic int idle_percent(input int phase_num, input bit receiver_side);
      case (phase_num)
         1: return receiver_side ? 0 : 48;
         2: return receiver_side ? 48 : 0;
         3: return 26;
         default: return 0;
      endcase
   endfunction

   function automatic int stim_phase();
      if (total_bytes == 0) return 0;
      return (bytes_offered * 5) / total_bytes;
   endfunction

   // Driver: updates the request channel at the falling edge. A byte that was
   // not yet taken stays on the port unchanged.
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_took) begin
            req_valid <= 1'b1;
         end else if (stream_bytes.size() > 0 &&
                      $urandom_range(99) >= idle_percent(stim_phase(), 1'b0)) begin
            req_valid <= 1'b1;
            req_in_byte <= stream_bytes.pop_front();
            bytes_offered++;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls per phase, plus one long hold-off that starts
   // inside the first long frame so that the block backs up and drops req_ready.
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!hold_done && rsp_valid && rsp_payload_length >= 16'd32) begin
            hold_done = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= idle_percent(stim_phase(), 1'b1));
         end
      end
   end

   // Monitor: at each rising edge a result transaction is checked against the
   // oldest expectation and an accepted byte is fed to the shadow parser.
   // A byte's result can only show up on a later edge, so the order is safe.
   always @(posedge clock) begin : monitor
      shdf_result_type want;
      if (reset) begin
         req_took <= 1'b0;
      end else begin
         req_took <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result with nothing expected, payload_byte 0x%0h",
                        $time, rsp_payload_byte);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("payload_byte", want.payload_byte, rsp_payload_byte);
               check_field("msg_id", want.msg_id, rsp_msg_id);
               check_field("format_code", want.format_code, rsp_format_code);
               check_field("payload_length", want.payload_length, rsp_payload_length);
               check_field("last_of_frame", want.last_of_frame, rsp_last_of_frame);
               check_field("empty_frame", want.empty_frame, rsp_empty_frame);
            end
         end
         if (req_valid && req_ready) begin
            deframe_byte(req_in_byte);
            bytes_taken++;
         end
      end
   end

   initial begin
      int len;
      bit first_random;
      first_random = 1'b1;

      // Directed part. Overlapping start: EB EB 91 EB 91 then the real sync word,
      // followed by an empty frame with id and format at their maximum.
      stream_bytes.push_back(8'hEB);
      stream_bytes.push_back(8'hEB);
      stream_bytes.push_back(8'h91);
      stream_bytes.push_back(8'hEB);
      stream_bytes.push_back(8'h91);
      queue_frame(16'd0, 16'hFFFF, 8'hFF, 0, 1'b0);
      // A lone 90 right after a frame must not complete a sync word.
      stream_bytes.push_back(SYNC_LAST);
      // Id and format at zero and a payload that holds the sync word.
      queue_frame(16'd4, 16'h0000, 8'h00, 4, 1'b1);
      stream_bytes.push_back(8'h00);
      stream_bytes.push_back(8'hFF);

      // Random part: mostly well-formed frames with random content, hunting
      // noise and broken sync words in between. The first frame is long
      // enough for the receiver hold-off.
      while (counted_bytes < COUNTED_BYTES) begin
         queue_hunt_bytes();
         if (first_random) begin
            len = 40;
            first_random = 1'b0;
         end else begin
            case ($urandom_range(19))
               0, 1, 2: len = 0;
               16, 17, 18: len = $urandom_range(24, 9);
               19: len = $urandom_range(60, 25);
               default: len = $urandom_range(8, 1);
            endcase
         end
         queue_frame(16'(len), 16'($urandom), 8'($urandom), len, 1'b0);
      end
      // Maximum length frame, cut off after a few payload bytes at the end of the run.
      queue_frame(16'hFFFF, 16'($urandom), 8'($urandom), 20, 1'b0);
      total_bytes = stream_bytes.size();

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (bytes_taken < total_bytes || expected_results.size() > 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (error_count == 0 && expected_results.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Safety net in case the block stops responding.
   initial begin
      #3000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
